// ----- rtl/core/scd_pkg.sv -----
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types and constants for the stopwatch countdown digits block.
// ----------------------------------------------------------------------------
package scd_pkg;

    // operation codes
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_WARN_ENABLE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_RED    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_GREEN  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_BLUE   = 8'd3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [7:0] COLOR_FULL  = 8'd255;
    localparam logic [7:0] COLOR_NONE  = 8'd0;

    // digit counter limits
    localparam logic [9:0] MS_LAST     = 10'd999;
    localparam logic [3:0] DIGIT_LAST  = 4'd9;
    localparam logic [3:0] SEXT_LAST   = 4'd5;

    localparam int WARN_WINDOW_MS = 10000;

    // elapsed time kept as decimal digits
    typedef struct packed {
        logic       hnz;     // hour count is nonzero
        logic [3:0] h_tens;  // saturates at 9
        logic [3:0] h_ones;
        logic [3:0] m_tens;
        logic [3:0] m_ones;
        logic [3:0] s_tens;
        logic [3:0] s_ones;
        logic [9:0] ms;
    } t_digits;

    typedef struct packed {
        logic inc;
        logic clr;
        logic load;
    } t_cnt_ctl;

endpackage

// ----- rtl/core/scd_time_count.sv -----
// ----------------------------------------------------------------------------
// scd_time_count
// Millisecond counter kept both in binary and as hh:mm:ss.ms digits.
// ----------------------------------------------------------------------------
module scd_time_count #(
    parameter int COUNT_WIDTH = 40
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  scd_pkg::t_cnt_ctl      i_ctl,
    input  logic [COUNT_WIDTH-1:0] i_load_count,
    input  scd_pkg::t_digits       i_load_digits,
    output logic [COUNT_WIDTH-1:0] o_count,
    output scd_pkg::t_digits       o_digits
);

    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    scd_pkg::t_digits       r_dig;
    scd_pkg::t_digits       n_dig;
    scd_pkg::t_digits       w_inc_dig;
    logic c_sec, c_s1, c_s10, c_m1, c_m10, c_h1;

    // ripple the decimal carries
    always_comb begin
        w_inc_dig = r_dig;
        c_sec = (r_dig.ms == scd_pkg::MS_LAST);
        c_s1  = c_sec && (r_dig.s_ones == scd_pkg::DIGIT_LAST);
        c_s10 = c_s1  && (r_dig.s_tens == scd_pkg::SEXT_LAST);
        c_m1  = c_s10 && (r_dig.m_ones == scd_pkg::DIGIT_LAST);
        c_m10 = c_m1  && (r_dig.m_tens == scd_pkg::SEXT_LAST);
        c_h1  = c_m10 && (r_dig.h_ones == scd_pkg::DIGIT_LAST);

        w_inc_dig.ms = c_sec ? 10'd0 : r_dig.ms + 10'd1;
        if (c_sec) begin
            w_inc_dig.s_ones = c_s1 ? 4'd0 : r_dig.s_ones + 4'd1;
        end
        if (c_s1) begin
            w_inc_dig.s_tens = c_s10 ? 4'd0 : r_dig.s_tens + 4'd1;
        end
        if (c_s10) begin
            w_inc_dig.m_ones = c_m1 ? 4'd0 : r_dig.m_ones + 4'd1;
        end
        if (c_m1) begin
            w_inc_dig.m_tens = c_m10 ? 4'd0 : r_dig.m_tens + 4'd1;
        end
        if (c_m10) begin
            w_inc_dig.hnz    = 1'b1;
            w_inc_dig.h_ones = c_h1 ? 4'd0 : r_dig.h_ones + 4'd1;
        end
        if (c_h1 && (r_dig.h_tens != scd_pkg::DIGIT_LAST)) begin
            w_inc_dig.h_tens = r_dig.h_tens + 4'd1;
        end
    end

    always_comb begin
        n_count = r_count;
        n_dig   = r_dig;
        if (i_ctl.clr) begin
            n_count = '0;
            n_dig   = '0;
        end else if (i_ctl.load) begin
            n_count = i_load_count;
            n_dig   = i_load_digits;
        end else if (i_ctl.inc) begin
            n_count = r_count + COUNT_WIDTH'(1);
            // binary wrap takes the digits back to zero too
            n_dig   = (&r_count) ? '0 : w_inc_dig;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_dig   <= '0;
        end else begin
            r_count <= n_count;
            r_dig   <= n_dig;
        end
    end

    assign o_count  = r_count;
    assign o_digits = r_dig;

endmodule

// ----- rtl/core/stopwatch_countdown_digits_unit.sv -----
// ----------------------------------------------------------------------------
// stopwatch_countdown_digits_unit
// Count-up timer with deadline and four-digit HH:MM / MM:SS display value.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one operation per beat:
//   start (stamps uptime, arms a deadline i_duration_ms later), tick (one
//   millisecond of uptime) or update (check deadline, emit display value).
//   Only update beats produce an output beat (o_out_valid / i_out_ready).
//   Config channel (i_cfg_valid / o_cfg_ready) is always ready; write only
//   while the block is idle.
// Latency / throughput:
//   One beat per cycle on the input while no update beat is held back by a
//   full output slot. An update result is presented the cycle after
//   acceptance from a single output register. Uptime and elapsed time are
//   kept as running decimal counters, so a compare and select sets the rate.
// Reset:
//   Uptime, elapsed time and deadline clear, timer disarmed, colour white,
//   warning off.
// Stall:
//   While an unread result sits in the output register, start and tick
//   beats are still taken; an update beat waits until the slot frees up.
// ----------------------------------------------------------------------------
module stopwatch_countdown_digits_unit #(
    parameter int COUNT_WIDTH = 40
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_operation,
    input  logic [30:0]                        i_duration_ms,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_ended,
    output logic                               o_hours_shown,
    output logic [3:0]                         o_digit_left_tens,
    output logic [3:0]                         o_digit_left_ones,
    output logic [3:0]                         o_digit_right_tens,
    output logic [3:0]                         o_digit_right_ones,
    output logic [7:0]                         o_color_red,
    output logic [7:0]                         o_color_green,
    output logic [7:0]                         o_color_blue,
    // config channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [scd_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [scd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // config registers
    logic       r_warn_en;
    logic [7:0] r_base_red;
    logic [7:0] r_base_green;
    logic [7:0] r_base_blue;

    // deadline state
    logic [COUNT_WIDTH:0] r_deadline;
    logic [COUNT_WIDTH:0] n_deadline;
    logic                 r_armed;
    logic                 n_armed;

    // output register
    logic       r_out_valid;
    logic       r_ended;
    logic       r_hours_shown;
    logic [3:0] r_dlt, r_dlo, r_drt, r_dro;
    logic [7:0] r_red, r_green, r_blue;

    // counters
    scd_pkg::t_cnt_ctl      w_up_ctl;
    scd_pkg::t_cnt_ctl      w_el_ctl;
    logic [COUNT_WIDTH-1:0] w_now;
    logic [COUNT_WIDTH-1:0] w_el_count;
    scd_pkg::t_digits       w_up_dig;
    scd_pkg::t_digits       w_el_dig;

    logic                 w_in_fire;
    logic                 w_is_start, w_is_tick, w_is_update;
    logic [COUNT_WIDTH:0] w_now_ext;
    logic [COUNT_WIDTH:0] w_start_deadline;
    logic [COUNT_WIDTH:0] w_to_go;
    logic                 w_hit;
    logic                 w_warn;

    assign w_is_start  = (i_operation == scd_pkg::OP_START);
    assign w_is_tick   = (i_operation == scd_pkg::OP_TICK);
    assign w_is_update = (i_operation == scd_pkg::OP_UPDATE);

    // only an update needs the output slot
    assign o_in_ready = !r_out_valid || i_out_ready || !w_is_update;
    assign w_in_fire  = i_in_valid && o_in_ready;

    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // uptime and elapsed counters
    // ------------------------------------------------------------------
    assign w_up_ctl = '{inc: w_in_fire && w_is_tick, clr: 1'b0, load: 1'b0};

    // start zeroes elapsed; a deadline end drops the start stamp, so
    // elapsed becomes raw uptime
    assign w_el_ctl = '{inc:  w_in_fire && w_is_tick,
                        clr:  w_in_fire && w_is_start,
                        load: w_in_fire && w_is_update && w_hit};

    scd_time_count #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_uptime (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_up_ctl),
        .i_load_count  ({COUNT_WIDTH{1'b0}}),
        .i_load_digits ('0),
        .o_count       (w_now),
        .o_digits      (w_up_dig)
    );

    scd_time_count #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_elapsed (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_el_ctl),
        .i_load_count  (w_now),
        .i_load_digits (w_up_dig),
        .o_count       (w_el_count),
        .o_digits      (w_el_dig)
    );

    // ------------------------------------------------------------------
    // deadline compare and warning window
    // ------------------------------------------------------------------
    assign w_now_ext        = {1'b0, w_now};
    assign w_start_deadline = w_now_ext + (COUNT_WIDTH+1)'(i_duration_ms);
    assign w_hit            = r_armed && (w_now_ext >= r_deadline);
    assign w_to_go          = r_deadline - w_now_ext;
    assign w_warn           = r_armed && r_warn_en && (r_deadline > w_now_ext) &&
                              (w_to_go <= (COUNT_WIDTH+1)'(scd_pkg::WARN_WINDOW_MS));

    always_comb begin
        n_deadline = r_deadline;
        n_armed    = r_armed;
        if (w_in_fire && w_is_start) begin
            n_deadline = w_start_deadline;
            // zero deadline never arms
            n_armed    = (w_start_deadline != '0);
        end else if (w_in_fire && w_is_update && w_hit) begin
            n_deadline = '0;
            n_armed    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadline <= '0;
            r_armed    <= 1'b0;
        end else begin
            r_deadline <= n_deadline;
            r_armed    <= n_armed;
        end
    end

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn_en    <= 1'b0;
            r_base_red   <= scd_pkg::COLOR_FULL;
            r_base_green <= scd_pkg::COLOR_FULL;
            r_base_blue  <= scd_pkg::COLOR_FULL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                scd_pkg::CFG_WARN_ENABLE: r_warn_en    <= i_cfg_data[0];
                scd_pkg::CFG_BASE_RED:    r_base_red   <= i_cfg_data;
                scd_pkg::CFG_BASE_GREEN:  r_base_green <= i_cfg_data;
                scd_pkg::CFG_BASE_BLUE:   r_base_blue  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire && w_is_update) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire && w_is_update) begin
            if (w_hit) begin
                // ended beat: everything but the flag reads zero
                r_ended       <= 1'b1;
                r_hours_shown <= 1'b0;
                r_dlt         <= 4'd0;
                r_dlo         <= 4'd0;
                r_drt         <= 4'd0;
                r_dro         <= 4'd0;
                r_red         <= scd_pkg::COLOR_NONE;
                r_green       <= scd_pkg::COLOR_NONE;
                r_blue        <= scd_pkg::COLOR_NONE;
            end else begin
                r_ended       <= 1'b0;
                r_hours_shown <= w_el_dig.hnz;
                if (w_el_dig.hnz) begin
                    r_dlt <= w_el_dig.h_tens;
                    r_dlo <= w_el_dig.h_ones;
                    r_drt <= w_el_dig.m_tens;
                    r_dro <= w_el_dig.m_ones;
                end else begin
                    r_dlt <= w_el_dig.m_tens;
                    r_dlo <= w_el_dig.m_ones;
                    r_drt <= w_el_dig.s_tens;
                    r_dro <= w_el_dig.s_ones;
                end
                r_red   <= w_warn ? scd_pkg::COLOR_FULL : r_base_red;
                r_green <= w_warn ? scd_pkg::COLOR_NONE : r_base_green;
                r_blue  <= w_warn ? scd_pkg::COLOR_NONE : r_base_blue;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_ended            = r_ended;
    assign o_hours_shown      = r_hours_shown;
    assign o_digit_left_tens  = r_dlt;
    assign o_digit_left_ones  = r_dlo;
    assign o_digit_right_tens = r_drt;
    assign o_digit_right_ones = r_dro;
    assign o_color_red        = r_red;
    assign o_color_green      = r_green;
    assign o_color_blue       = r_blue;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // an armed timer always holds a nonzero deadline
    a_armed_deadline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> (r_deadline != '0))
        else $error("armed with zero deadline");

    // a deadline hit on an update disarms and clears the deadline
    a_hit_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_is_update && w_hit) |=> (!r_armed && (r_deadline == '0)))
        else $error("deadline hit did not disarm");

    // input stalls only when an update meets a full, unread output slot
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_out_valid && !i_out_ready && w_is_update))
        else $error("input stalled without cause");

    // elapsed counter is zero right after a start
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_is_start) |=> (w_el_count == '0))
        else $error("start did not clear elapsed time");

endmodule

// ----- test/stopwatch_countdown_digits_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stopwatch_countdown_digits_unit_tb
// Self-checking bench for the stopwatch countdown digits block. A timer
// predictor runs next to the DUT and every update beat's display value is
// checked against it, field by field. Directed tests cover reset view,
// deadlines, warning colour, output back-pressure and a long back-to-back
// stretch; random start/tick/update runs then sweep several colour and
// warning settings with random idling on both channels.
// ----------------------------------------------------------------------------
module stopwatch_countdown_digits_unit_tb;

    localparam int TIMER_W      = 40;
    localparam int QUIET_LIMIT  = 1000;   // cycles with no beat on any channel
    localparam int HOLD_CYCLES  = 48;     // long receiver hold-off
    localparam int SETTLE_CYCLES = 4;     // result register latency plus margin
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT     = 31;
    localparam int RANDOM_ITEMS = 140;    // per random phase
    localparam int LONG_TICKS   = 48;     // ticks in the no-idle stretch

    // operation code the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // register index outside the map, writes must be dropped
    localparam logic [scd_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 8'd4;

    localparam longint unsigned MS_PER_SEC  = 1000;
    localparam longint unsigned MS_PER_MIN  = 60000;
    localparam longint unsigned MS_PER_HOUR = 3600000;

    typedef struct packed {
        logic       ended;
        logic       hours_shown;
        logic [3:0] left_tens;
        logic [3:0] left_ones;
        logic [3:0] right_tens;
        logic [3:0] right_ones;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_display;

    typedef struct packed {
        logic [scd_pkg::CFG_INDEX_W-1:0] index;
        logic [scd_pkg::CFG_DATA_W-1:0]  data;
    } t_reg_write;

    // ------------------------------------------------------------------------
    // clock, DUT ports
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic                            i_rst_n       = 1'b0;
    logic                            i_in_valid    = 1'b0;
    logic                            o_in_ready;
    logic [1:0]                      i_operation   = scd_pkg::OP_TICK;
    logic [30:0]                     i_duration_ms = '0;
    logic                            o_out_valid;
    logic                            i_out_ready   = 1'b0;
    logic                            o_ended;
    logic                            o_hours_shown;
    logic [3:0]                      o_digit_left_tens;
    logic [3:0]                      o_digit_left_ones;
    logic [3:0]                      o_digit_right_tens;
    logic [3:0]                      o_digit_right_ones;
    logic [7:0]                      o_color_red;
    logic [7:0]                      o_color_green;
    logic [7:0]                      o_color_blue;
    logic                            i_cfg_valid   = 1'b0;
    logic                            o_cfg_ready;
    logic [scd_pkg::CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [scd_pkg::CFG_DATA_W-1:0]  i_cfg_data    = '0;

    stopwatch_countdown_digits_unit #(
        .COUNT_WIDTH (TIMER_W)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_operation        (i_operation),
        .i_duration_ms      (i_duration_ms),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_ended            (o_ended),
        .o_hours_shown      (o_hours_shown),
        .o_digit_left_tens  (o_digit_left_tens),
        .o_digit_left_ones  (o_digit_left_ones),
        .o_digit_right_tens (o_digit_right_tens),
        .o_digit_right_ones (o_digit_right_ones),
        .o_color_red        (o_color_red),
        .o_color_green      (o_color_green),
        .o_color_blue       (o_color_blue),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // timer predictor: own copy of uptime, stamps and colour registers
    // ------------------------------------------------------------------------
    logic [TIMER_W-1:0] up_ms;
    logic [TIMER_W-1:0] start_ms;
    logic [TIMER_W:0]   due_ms;      // one bit wider, never wraps
    logic               armed;
    logic               warn_on;
    logic [7:0]         base_r;
    logic [7:0]         base_g;
    logic [7:0]         base_b;

    t_display   expected_displays[$];  // display values still owed by the DUT
    t_reg_write cfg_plan[$];           // register writes for the next program_config
    int         mismatches = 0;

    // flags shared with the receiver process
    bit steady     = 1'b0;   // no idling on either side
    int hold_asks  = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int quiet_cycles = 0;

    task automatic reset_timer_model();
        up_ms    = '0;
        start_ms = '0;
        due_ms   = '0;
        armed    = 1'b0;
        warn_on  = 1'b0;
        base_r   = scd_pkg::COLOR_FULL;
        base_g   = scd_pkg::COLOR_FULL;
        base_b   = scd_pkg::COLOR_FULL;
    endtask

    task automatic apply_config(input t_reg_write w);
        case (w.index)
            scd_pkg::CFG_WARN_ENABLE: warn_on = w.data[0];
            scd_pkg::CFG_BASE_RED:    base_r  = w.data;
            scd_pkg::CFG_BASE_GREEN:  base_g  = w.data;
            scd_pkg::CFG_BASE_BLUE:   base_b  = w.data;
            default: ;
        endcase
    endtask

    // Advance the timer by one accepted beat; an update owes one display value.
    task automatic advance_timer(input logic [1:0] op, input logic [30:0] dur);
        t_display           d;
        logic [TIMER_W-1:0] span;
        longint unsigned    ms, hrs, mins, secs, rem_sec, rem_min, h_tens;
        logic               warn;
        d = '0;
        case (op)
            scd_pkg::OP_START: begin
                start_ms = up_ms;
                due_ms   = {1'b0, up_ms} + {{(TIMER_W - 30){1'b0}}, dur};
                // zero deadline (uptime and duration both zero) stays disarmed
                armed    = (due_ms != '0);
            end
            scd_pkg::OP_TICK: up_ms = up_ms + 1'b1;
            scd_pkg::OP_UPDATE: begin
                if (armed && ({1'b0, up_ms} >= due_ms)) begin
                    // deadline hit: report ended with everything else zero, disarm
                    armed    = 1'b0;
                    start_ms = '0;
                    due_ms   = '0;
                    d.ended  = 1'b1;
                end else begin
                    span    = up_ms - start_ms;       // modulo the counter width
                    ms      = span;
                    hrs     = ms / MS_PER_HOUR;
                    mins    = ms / MS_PER_MIN;
                    secs    = ms / MS_PER_SEC;
                    rem_sec = secs - mins * 60;
                    rem_min = mins - hrs * 60;
                    h_tens  = hrs / 10;
                    if (h_tens > 9) h_tens = 9;       // hours tens saturates
                    warn = armed && warn_on && (due_ms > {1'b0, up_ms}) &&
                           ((due_ms - {1'b0, up_ms}) <= scd_pkg::WARN_WINDOW_MS);
                    if (hrs != 0) begin
                        d.hours_shown = 1'b1;
                        d.left_tens   = 4'(h_tens);
                        d.left_ones   = 4'(hrs % 10);
                        d.right_tens  = 4'(rem_min / 10);
                        d.right_ones  = 4'(rem_min % 10);
                    end else begin
                        d.left_tens   = 4'(rem_min / 10);
                        d.left_ones   = 4'(rem_min % 10);
                        d.right_tens  = 4'(rem_sec / 10);
                        d.right_ones  = 4'(rem_sec % 10);
                    end
                    d.red   = warn ? scd_pkg::COLOR_FULL : base_r;
                    d.green = warn ? scd_pkg::COLOR_NONE : base_g;
                    d.blue  = warn ? scd_pkg::COLOR_NONE : base_b;
                end
                expected_displays.push_back(d);
            end
            default: ;  // unused code: no state change, no result
        endcase
    endtask

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    function automatic string show(input t_display d);
        return $sformatf("ended=%0d hours=%0d digits=%0d%0d:%0d%0d rgb=%0d/%0d/%0d",
                         d.ended, d.hours_shown, d.left_tens, d.left_ones,
                         d.right_tens, d.right_ones, d.red, d.green, d.blue);
    endfunction

    always @(posedge i_clk) begin
        t_display got;
        t_display want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_ended, o_hours_shown, o_digit_left_tens, o_digit_left_ones,
                   o_digit_right_tens, o_digit_right_ones,
                   o_color_red, o_color_green, o_color_blue};
            if (expected_displays.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: display beat with none pending: %s", $realtime, show(got));
            end else begin
                want = expected_displays.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: display differs\n  exp %s\n  got %s",
                                 $realtime, show(want), show(got));
                end
            end
        end
    end

    // receiver: random stalls, steady stretches, and requested long hold-offs
    always @(posedge i_clk) begin
        if (hold_seen != hold_asks) begin
            hold_seen   <= hold_asks;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (steady) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog: ends the run when no channel moves a beat for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("stopwatch_countdown_digits_unit: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    // One input beat: optional idle gap, then hold valid until accepted.
    task automatic send_item(input logic [1:0] op, input logic [30:0] dur);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_duration_ms <= dur;
        do @(posedge i_clk); while (!o_in_ready);
        advance_timer(op, dur);
    endtask

    // Idle the input and let every owed display value drain out.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_displays.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void plan_write(input logic [scd_pkg::CFG_INDEX_W-1:0] idx,
                                       input logic [scd_pkg::CFG_DATA_W-1:0] data);
        cfg_plan.push_back({idx, data});
    endfunction

    // Write the planned registers back to back while the block is idle.
    task automatic program_config();
        settle();
        foreach (cfg_plan[k]) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= cfg_plan[k].index;
            i_cfg_data  <= cfg_plan[k].data;
            do @(posedge i_clk); while (!o_cfg_ready);
            apply_config(cfg_plan[k]);
        end
        i_cfg_valid <= 1'b0;
        cfg_plan.delete();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // Reset colour and blank display; a start at uptime zero with zero
    // duration must not arm; the unused code is ignored.
    task automatic test_reset_view();
        send_item(scd_pkg::OP_UPDATE, '0);
        send_item(scd_pkg::OP_START, '0);
        send_item(scd_pkg::OP_TICK, '0);
        send_item(OP_UNUSED, 31'h7FFF_FFFF);
        send_item(scd_pkg::OP_UPDATE, '0);
    endtask

    // Deadlines reached at once and after a few ticks; after ending, updates
    // show raw uptime. Alternating duration patterns toggle every bit.
    task automatic test_deadline();
        send_item(scd_pkg::OP_START, '0);          // uptime nonzero: arms, due now
        send_item(scd_pkg::OP_UPDATE, '0);
        send_item(scd_pkg::OP_UPDATE, '0);
        send_item(scd_pkg::OP_START, 31'd2);
        send_item(scd_pkg::OP_TICK, '0);
        send_item(scd_pkg::OP_UPDATE, '0);
        send_item(scd_pkg::OP_TICK, '0);
        send_item(scd_pkg::OP_UPDATE, '0);
        send_item(scd_pkg::OP_START, 31'h2AAA_AAAA);
        send_item(scd_pkg::OP_UPDATE, '0);
        send_item(scd_pkg::OP_START, 31'h5555_5555);
        send_item(scd_pkg::OP_UPDATE, '0);
    endtask

    // Warning window edge (10001 ms out vs 10000) and a warned deadline.
    task automatic test_warning();
        plan_write(scd_pkg::CFG_WARN_ENABLE, 8'h01);
        plan_write(scd_pkg::CFG_BASE_RED,    8'h12);
        plan_write(scd_pkg::CFG_BASE_GREEN,  8'h34);
        plan_write(scd_pkg::CFG_BASE_BLUE,   8'h56);
        program_config();
        send_item(scd_pkg::OP_START, 31'd10001);
        send_item(scd_pkg::OP_UPDATE, '0);
        send_item(scd_pkg::OP_TICK, '0);
        send_item(scd_pkg::OP_UPDATE, '0);
        send_item(scd_pkg::OP_START, 31'd4);
        repeat (4) send_item(scd_pkg::OP_TICK, '0);
        send_item(scd_pkg::OP_UPDATE, '0);
        send_item(scd_pkg::OP_UPDATE, '0);         // disarmed: base colour again
    endtask

    // Receiver holds off while updates keep coming: the result register
    // fills and later update beats must wait.
    task automatic test_backpressure();
        hold_asks++;
        send_item(scd_pkg::OP_UPDATE, '0);
        send_item(scd_pkg::OP_TICK, 31'($urandom));
        send_item(scd_pkg::OP_UPDATE, '0);
        send_item(scd_pkg::OP_START, 31'd20);
        send_item(scd_pkg::OP_UPDATE, '0);
        send_item(scd_pkg::OP_TICK, '0);
        send_item(scd_pkg::OP_UPDATE, '0);
    endtask

    // Long stretch with no idling: ticks and updates back to back, with the
    // deadline at the far end of its range.
    task automatic test_long_count();
        steady = 1'b1;
        send_item(scd_pkg::OP_START, 31'h7FFF_FFFF);
        for (int i = 1; i <= LONG_TICKS; i++) begin
            send_item(scd_pkg::OP_TICK, '0);
            if (i % 6 == 0)
                send_item(scd_pkg::OP_UPDATE, '0);
        end
        steady = 1'b0;
    endtask

    // Start followed by a random run of ticks and updates, with noise.
    task automatic random_traffic(input int n_items);
        int          sent;
        int          pick;
        int          run_len;
        logic [30:0] dur;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 50)      dur = 31'($urandom_range(40));
            else if (pick < 75) dur = 31'($urandom_range(10030, 9990));  // warn edge
            else if (pick < 85) dur = 31'($urandom_range(12000));
            else                dur = 31'($urandom);
            send_item(scd_pkg::OP_START, dur);
            sent++;
            run_len = $urandom_range(40, 4);
            repeat (run_len) begin
                pick = $urandom_range(99);
                if (pick < 58) begin
                    send_item(scd_pkg::OP_TICK, 31'($urandom));
                    sent++;
                end else if (pick < 93) begin
                    send_item(scd_pkg::OP_UPDATE, 31'($urandom));
                    sent++;
                end else if (pick < 97) begin
                    send_item(OP_UNUSED, 31'($urandom));
                end else begin
                    send_item(scd_pkg::OP_START, 31'($urandom_range(60)));  // restart mid-run
                    sent++;
                end
            end
        end
    endtask

    // Random runs under several register settings, extremes first.
    task automatic test_random_phases();
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    plan_write(scd_pkg::CFG_WARN_ENABLE, 8'h01);
                    plan_write(scd_pkg::CFG_BASE_RED,    8'h00);
                    plan_write(scd_pkg::CFG_BASE_GREEN,  8'h00);
                    plan_write(scd_pkg::CFG_BASE_BLUE,   8'h00);
                end
                1: begin
                    plan_write(scd_pkg::CFG_WARN_ENABLE, 8'hFE);   // only bit 0 counts
                    plan_write(scd_pkg::CFG_BASE_RED,    8'hFF);
                    plan_write(scd_pkg::CFG_BASE_GREEN,  8'hFF);
                    plan_write(scd_pkg::CFG_BASE_BLUE,   8'hFF);
                    plan_write(CFG_SPARE,                8'hA5);
                end
                default: begin
                    plan_write(scd_pkg::CFG_WARN_ENABLE, 8'($urandom));
                    plan_write(scd_pkg::CFG_BASE_RED,    8'($urandom));
                    plan_write(scd_pkg::CFG_BASE_GREEN,  8'($urandom));
                    plan_write(scd_pkg::CFG_BASE_BLUE,   8'($urandom));
                end
            endcase
            program_config();
            random_traffic(RANDOM_ITEMS);
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        reset_timer_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_view();
        test_deadline();
        test_warning();
        test_backpressure();
        test_long_count();
        test_random_phases();

        i_in_valid <= 1'b0;
        while (expected_displays.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_displays.size() == 0)
            $display("stopwatch_countdown_digits_unit: match");
        else
            $display("stopwatch_countdown_digits_unit: mismatch");
        $finish;
    end

endmodule
